>>> src/rtfr_pkg.sv
// ----------------------------------------------------------------------------
// rtfr_pkg: shared types and constants
// Sync key, salt, LED segment tables and queue types for the frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtfr_pkg;

    // Configuration register indexes
    localparam logic CFG_TICKS_PER_SECOND = 1'b0;
    localparam logic CFG_TIMEOUT_SECONDS  = 1'b1;

    localparam int CFG_DATA_W = 10;

    localparam logic [7:0] SYNC_KEY [16] = '{
        8'hff, 8'h8d, 8'h4a, 8'he0, 8'h84, 8'h09, 8'hd6, 8'hb2,
        8'hd6, 8'h70, 8'hb1, 8'h7b, 8'hbd, 8'h06, 8'h6b, 8'h2c
    };

    localparam logic [7:0] SALT [8] = '{
        8'h80, 8'h59, 8'h4a, 8'hb7, 8'h39, 8'hbe, 8'h73, 8'h51
    };

    localparam logic [7:0] INVALID_VALUE = 8'hff;

    // Segment masks packed as {A, C, F, G}
    localparam logic [31:0] DASH_MASK     = 32'h0802_0000;
    localparam logic [31:0] HUNDREDS_MASK = 32'h0000_3000;

    typedef struct packed {
        logic [7:0] value;
        logic       invalid;
    } rtfr_event_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } rtfr_q_stat_t;

    function automatic logic [31:0] tens_mask(input logic [3:0] digit);
        logic [31:0] m;
        case (digit)
            4'd0:    m = 32'h060c_0c00;
            4'd1:    m = 32'h0204_0000;
            4'd2:    m = 32'h0a08_0c00;
            4'd3:    m = 32'h0a0c_0400;
            4'd4:    m = 32'h0e04_0000;
            4'd5:    m = 32'h0c0c_0400;
            4'd6:    m = 32'h0c0c_0c00;
            4'd7:    m = 32'h020c_0000;
            4'd8:    m = 32'h0e0c_0c00;
            4'd9:    m = 32'h0e0c_0400;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] ones_mask(input logic [3:0] digit);
        logic [31:0] m;
        case (digit)
            4'd0:    m = 32'h2001_0303;
            4'd1:    m = 32'h0000_0003;
            4'd2:    m = 32'h2002_0302;
            4'd3:    m = 32'h0002_0303;
            4'd4:    m = 32'h0003_0003;
            4'd5:    m = 32'h0003_0301;
            4'd6:    m = 32'h2003_0301;
            4'd7:    m = 32'h0000_0103;
            4'd8:    m = 32'h2003_0303;
            4'd9:    m = 32'h0003_0303;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> src/rtfr_front.sv
// ----------------------------------------------------------------------------
// rtfr_front: sync hunt, payload check and seconds timer
// Updates all receiver state per transfer and pushes display events.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtfr_front
    import rtfr_pkg::*;
#(
    parameter int KEY_LENGTH     = 16,
    parameter int PAYLOAD_COPIES = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_fire,
    input  wire logic                  func,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  cfg_fire,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       push,
    output rtfr_event_t                push_data
);

    localparam int KW = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
    localparam int PW = (PAYLOAD_COPIES > 1) ? $clog2(PAYLOAD_COPIES) : 1;

    logic [9:0]    tps_reg,       tps_next;
    logic [7:0]    timeout_reg,   timeout_next;
    logic          phase_reg,     phase_next;
    logic [KW-1:0] key_cnt_reg,   key_cnt_next;
    logic [PW-1:0] pay_cnt_reg,   pay_cnt_next;
    logic [7:0]    first_reg,     first_next;
    logic          disagree_reg,  disagree_next;
    logic [7:0]    held_reg,      held_next;
    logic          invalid_reg,   invalid_next;
    logic [7:0]    idle_reg,      idle_next;
    logic [9:0]    tick_reg,      tick_next;

    logic [9:0] tick_inc;
    logic [7:0] key_byte;
    logic [7:0] plain;
    logic [7:0] first_now;
    logic       disagree_now;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tps_reg      <= 10'd250;
            timeout_reg  <= 8'd60;
            phase_reg    <= 1'b0;
            key_cnt_reg  <= '0;
            pay_cnt_reg  <= '0;
            first_reg    <= 8'd0;
            disagree_reg <= 1'b0;
            held_reg     <= 8'hff;
            invalid_reg  <= 1'b1;
            idle_reg     <= 8'd0;
            tick_reg     <= 10'd0;
        end else begin
            tps_reg      <= tps_next;
            timeout_reg  <= timeout_next;
            phase_reg    <= phase_next;
            key_cnt_reg  <= key_cnt_next;
            pay_cnt_reg  <= pay_cnt_next;
            first_reg    <= first_next;
            disagree_reg <= disagree_next;
            held_reg     <= held_next;
            invalid_reg  <= invalid_next;
            idle_reg     <= idle_next;
            tick_reg     <= tick_next;
        end
    end

    assign tick_inc     = tick_reg + 10'd1;
    assign key_byte     = SYNC_KEY[4'(key_cnt_reg)];
    assign plain        = rx_byte ^ SALT[3'(pay_cnt_reg)];
    assign first_now    = (pay_cnt_reg == '0) ? plain : first_reg;
    assign disagree_now = (pay_cnt_reg == '0) ? 1'b0
                        : (disagree_reg | (plain != first_reg));

    always_comb begin
        tps_next      = tps_reg;
        timeout_next  = timeout_reg;
        phase_next    = phase_reg;
        key_cnt_next  = key_cnt_reg;
        pay_cnt_next  = pay_cnt_reg;
        first_next    = first_reg;
        disagree_next = disagree_reg;
        held_next     = held_reg;
        invalid_next  = invalid_reg;
        idle_next     = idle_reg;
        tick_next     = tick_reg;
        push          = 1'b0;

        if (cfg_fire) begin
            unique case (cfg_index)
                CFG_TICKS_PER_SECOND: tps_next     = cfg_data;
                CFG_TIMEOUT_SECONDS:  timeout_next = cfg_data[7:0];
                default:              ;
            endcase
        end

        if (in_fire) begin
            if (func) begin
                if (tick_inc >= tps_reg) begin
                    tick_next = 10'd0;
                    if (idle_reg < timeout_reg) begin
                        idle_next = idle_reg + 8'd1;
                    end else begin
                        invalid_next = 1'b1;
                    end
                    push = 1'b1;
                end else begin
                    tick_next = tick_inc;
                end
            end else if (!phase_reg) begin
                if (rx_byte == key_byte) begin
                    if (key_cnt_reg == KW'(KEY_LENGTH - 1)) begin
                        phase_next   = 1'b1;
                        pay_cnt_next = '0;
                        key_cnt_next = '0;
                    end else begin
                        key_cnt_next = key_cnt_reg + KW'(1);
                    end
                end else if (rx_byte == SYNC_KEY[0]) begin
                    key_cnt_next = KW'(1);
                end else begin
                    key_cnt_next = '0;
                end
            end else begin
                first_next    = first_now;
                disagree_next = disagree_now;
                if (pay_cnt_reg == PW'(PAYLOAD_COPIES - 1)) begin
                    phase_next   = 1'b0;
                    pay_cnt_next = '0;
                    key_cnt_next = '0;
                    if (!disagree_now) begin
                        idle_next    = 8'd0;
                        held_next    = first_now;
                        invalid_next = (first_now == INVALID_VALUE);
                        push         = 1'b1;
                    end
                end else begin
                    pay_cnt_next = pay_cnt_reg + PW'(1);
                end
            end
        end
    end

    assign push_data.value   = held_next;
    assign push_data.invalid = invalid_next;

endmodule

`default_nettype wire

>>> src/rtfr_fifo.sv
// ----------------------------------------------------------------------------
// rtfr_fifo: two-entry event queue
// Decouples the receiver front end from the display back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtfr_fifo
    import rtfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire rtfr_event_t push_data,
    input  wire logic        pop,
    output rtfr_event_t      pop_data,
    output rtfr_q_stat_t     stat
);

    rtfr_event_t entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    assign pop_data       = entry_reg[rd_ptr_reg];
    assign stat.full      = (count_reg == 2'd2);
    assign stat.not_empty = (count_reg != 2'd0);

endmodule

`default_nettype wire

>>> src/rtfr_back.sv
// ----------------------------------------------------------------------------
// rtfr_back: display decode and output register
// Splits the reading into digits and builds the LED port masks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtfr_back
    import rtfr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire rtfr_q_stat_t q_stat,
    input  wire rtfr_event_t  q_data,
    output logic              pop,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [7:0]        port_a_leds,
    output logic [7:0]        port_c_leds,
    output logic [7:0]        port_f_leds,
    output logic [7:0]        port_g_leds,
    output logic [7:0]        shown_value,
    output logic              reading_valid
);

    logic        valid_reg, valid_next;
    logic [31:0] mask_reg;
    logic [7:0]  value_reg;
    logic        rvalid_reg;

    logic        over_99;
    logic [6:0]  rem;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [31:0] mask;

    // value mod 100 by range compare, then tens by reciprocal (exact below 1029)
    always_comb begin
        over_99   = (q_data.value > 8'd99);
        if (q_data.value >= 8'd200) begin
            rem = 7'(q_data.value - 8'd200);
        end else if (over_99) begin
            rem = 7'(q_data.value - 8'd100);
        end else begin
            rem = q_data.value[6:0];
        end
        tens_prod = 15'(rem) * 15'd205;
        tens      = tens_prod[14:11];
        ones      = 4'(rem - (7'(tens) * 7'd10));

        if (q_data.invalid) begin
            mask = DASH_MASK;
        end else begin
            mask = ones_mask(ones);
            if (over_99) begin
                mask = mask | HUNDREDS_MASK;
            end
            if (over_99 || rem > 7'd9) begin
                mask = mask | tens_mask(tens);
            end
        end
    end

    assign pop        = q_stat.not_empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (pop) begin
            mask_reg   <= mask;
            value_reg  <= q_data.value;
            rvalid_reg <= ~q_data.invalid;
        end
    end

    assign out_valid     = valid_reg;
    assign port_a_leds   = mask_reg[31:24];
    assign port_c_leds   = mask_reg[23:16];
    assign port_f_leds   = mask_reg[15:8];
    assign port_g_leds   = mask_reg[7:0];
    assign shown_value   = value_reg;
    assign reading_valid = rvalid_reg;

endmodule

`default_nettype wire

>>> src/radio_temperature_frame_receiver.sv
// ----------------------------------------------------------------------------
// radio_temperature_frame_receiver: sync-word frame receiver with LED driver
// Throughput: one item per cycle while the queue has a free slot; the front
// end updates all state in the accepting cycle, and the decode back end
// takes one queued event per cycle while its output register is empty or
// being taken; a result passes through the queue and the output register.
// Reset: asynchronous, active low; registers return to 250 ticks and 60 s,
// the reading starts invalid (0xFF) and the queue and output are emptied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radio_temperature_frame_receiver
    import rtfr_pkg::*;
#(
    parameter int KEY_LENGTH     = 16,
    parameter int PAYLOAD_COPIES = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input item channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  func,
    input  wire logic [7:0]            rx_byte,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 port_a_leds,
    output logic [7:0]                 port_c_leds,
    output logic [7:0]                 port_f_leds,
    output logic [7:0]                 port_g_leds,
    output logic [7:0]                 shown_value,
    output logic                       reading_valid,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    rtfr_event_t  push_data;
    rtfr_event_t  pop_data;
    rtfr_q_stat_t q_stat;
    logic         push;
    logic         pop;
    logic         in_fire;
    logic         cfg_fire;

    // Any item may produce an event, so a transfer needs a free queue slot.
    assign in_ready  = ~q_stat.full;
    assign in_fire   = in_valid & in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    // Front end: key hunt, payload check, second timer and timeout.
    rtfr_front #(
        .KEY_LENGTH     (KEY_LENGTH),
        .PAYLOAD_COPIES (PAYLOAD_COPIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .func      (func),
        .rx_byte   (rx_byte),
        .cfg_fire  (cfg_fire),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_data (push_data)
    );

    // Queue of display events (reading snapshot plus invalid flag).
    rtfr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    // Back end: digit split, segment masks, output register.
    rtfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_data        (pop_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .port_a_leds   (port_a_leds),
        .port_c_leds   (port_c_leds),
        .port_f_leds   (port_f_leds),
        .port_g_leds   (port_g_leds),
        .shown_value   (shown_value),
        .reading_valid (reading_valid)
    );

    // The front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && q_stat.full))
        else $error("event pushed into full queue");

    // A valid reading is never the invalid marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reading_valid) |-> (shown_value != INVALID_VALUE))
        else $error("valid reading carries invalid marker");

    // An invalid reading shows dashes only.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reading_valid) |->
            (port_a_leds == DASH_MASK[31:24] && port_c_leds == DASH_MASK[23:16] &&
             port_f_leds == DASH_MASK[15:8] && port_g_leds == DASH_MASK[7:0]))
        else $error("invalid reading without dash mask");

    // A popped event lands in the output register on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) pop |=> out_valid)
        else $error("popped event lost");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the radio temperature frame receiver
// Feeds radio bytes and timer ticks through the input channel and checks
// every LED display result against a cycle-free behavioral copy of the
// receiver. Directed frames and register corners come first. Random traffic
// follows, mostly well-formed frames with random readings mixed with ticks,
// noise and broken frames, over several register settings and idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int KEY_BYTES    = 16;
    localparam int COPIES       = 4;
    localparam int DRAIN_CYCLES = 8;     // idle time after the queues have drained
    localparam int STALL_LIMIT  = 4000;  // cycles with no transfer on any channel

    // Sync key and per-copy salt, as sent on air
    localparam logic [7:0] KEY_SEQ [KEY_BYTES] = '{
        8'hff, 8'h8d, 8'h4a, 8'he0, 8'h84, 8'h09, 8'hd6, 8'hb2,
        8'hd6, 8'h70, 8'hb1, 8'h7b, 8'hbd, 8'h06, 8'h6b, 8'h2c
    };
    localparam logic [7:0] SALT_SEQ [8] = '{
        8'h80, 8'h59, 8'h4a, 8'hb7, 8'h39, 8'hbe, 8'h73, 8'h51
    };

    // Segment patterns packed as {A, C, F, G}
    localparam logic [31:0] SEG_DASH     = 32'h0802_0000;
    localparam logic [31:0] SEG_HUNDREDS = 32'h0000_3000;
    localparam logic [31:0] SEG_TENS [10] = '{
        32'h060c_0c00, 32'h0204_0000, 32'h0a08_0c00, 32'h0a0c_0400, 32'h0e04_0000,
        32'h0c0c_0400, 32'h0c0c_0c00, 32'h020c_0000, 32'h0e0c_0c00, 32'h0e0c_0400
    };
    localparam logic [31:0] SEG_ONES [10] = '{
        32'h2001_0303, 32'h0000_0003, 32'h2002_0302, 32'h0002_0303, 32'h0003_0003,
        32'h0003_0301, 32'h2003_0301, 32'h0000_0103, 32'h2003_0303, 32'h0003_0303
    };

    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] port_a;
        logic [7:0] port_c;
        logic [7:0] port_f;
        logic [7:0] port_g;
        logic [7:0] value;
        logic       valid;
    } display_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic                           func      = 1'b0;
    logic [7:0]                     rx_byte   = 8'h00;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [7:0]                     port_a_leds;
    logic [7:0]                     port_c_leds;
    logic [7:0]                     port_f_leds;
    logic [7:0]                     port_g_leds;
    logic [7:0]                     shown_value;
    logic                           reading_valid;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic                           cfg_index = 1'b0;
    logic [rtfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    radio_temperature_frame_receiver i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .port_a_leds   (port_a_leds),
        .port_c_leds   (port_c_leds),
        .port_f_leds   (port_f_leds),
        .port_g_leds   (port_g_leds),
        .shown_value   (shown_value),
        .reading_valid (reading_valid),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    rx_item_t rx_items [$];           // items waiting for the driver
    display_t pending_displays [$];   // predicted results, oldest first
    rx_item_t drive_item;
    int       items_queued   = 0;
    int       mismatches     = 0;
    int       stall_cycles   = 0;
    int       send_idle_pct  = 0;
    int       recv_idle_pct  = 0;
    logic     in_taken       = 1'b0;  // input transfer seen at the last rising edge

    // Receiver model: registers and state after reset
    logic [9:0] model_tps        = 10'd250;
    logic [7:0] model_timeout    = 8'd60;
    logic       in_payload       = 1'b0;
    logic [4:0] key_pos          = '0;
    logic [2:0] copy_idx         = '0;
    logic [7:0] first_copy       = '0;
    logic       copies_differ    = 1'b0;
    logic [7:0] held_reading     = 8'hff;
    logic       reading_dashed   = 1'b1;
    logic [7:0] quiet_seconds    = '0;
    logic [9:0] tick_total       = '0;

    // ------------------------------------------------------------------
    // Display pattern for a held reading. The hundreds digit can only be
    // a one, so 200..254 show as 1 followed by the value mod 100.
    // ------------------------------------------------------------------
    function automatic display_t led_pattern(input logic [7:0] value, input logic dashed);
        display_t   d;
        logic [31:0] m;
        int          n;
        logic        hundreds;
        m        = '0;
        n        = value;
        hundreds = 1'b0;
        if (dashed)
        begin
            m = SEG_DASH;
        end
        else
        begin
            if (n > 99)
            begin
                n        = n % 100;
                hundreds = 1'b1;
                m        = m | SEG_HUNDREDS;
            end
            // leading zero of the tens digit is kept once hundreds is lit
            if (n > 9 || hundreds)
            begin
                m = m | SEG_TENS[n / 10];
                n = n % 10;
            end
            m = m | SEG_ONES[n];
        end
        d.port_a = m[31:24];
        d.port_c = m[23:16];
        d.port_f = m[15:8];
        d.port_g = m[7:0];
        d.value  = value;
        d.valid  = !dashed;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Advance the receiver model by one accepted item; queue the display
    // it causes, if any.
    // ------------------------------------------------------------------
    task automatic receive_item(input rx_item_t item);
        logic [7:0] plain;
        if (item.is_tick)
        begin
            tick_total = tick_total + 10'd1;
            // >= also covers a count left above a freshly lowered limit
            if (tick_total >= model_tps)
            begin
                tick_total = '0;
                if (quiet_seconds < model_timeout)
                    quiet_seconds = quiet_seconds + 8'd1;
                else
                    reading_dashed = 1'b1;
                pending_displays.push_back(led_pattern(held_reading, reading_dashed));
            end
        end
        else if (!in_payload)
        begin
            if (item.data == KEY_SEQ[key_pos[3:0]])
            begin
                key_pos = key_pos + 5'd1;
                if (key_pos >= KEY_BYTES)
                begin
                    in_payload = 1'b1;
                    copy_idx   = '0;
                    key_pos    = '0;
                end
            end
            else if (item.data == KEY_SEQ[0])
                key_pos = 5'd1;     // mismatching byte may itself open a key
            else
                key_pos = '0;
        end
        else
        begin
            plain = item.data ^ SALT_SEQ[copy_idx];
            if (copy_idx == 3'd0)
            begin
                first_copy    = plain;
                copies_differ = 1'b0;
            end
            else if (plain != first_copy)
                copies_differ = 1'b1;
            if (int'(copy_idx) + 1 >= COPIES)
            begin
                in_payload = 1'b0;
                copy_idx   = '0;
                key_pos    = '0;
                if (!copies_differ)
                begin
                    quiet_seconds  = '0;
                    held_reading   = first_copy;
                    reading_dashed = (first_copy == 8'hff);
                    pending_displays.push_back(led_pattern(held_reading, reading_dashed));
                end
            end
            else
                copy_idx = copy_idx + 3'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: input channel and receiver back-pressure, both changed on
    // the falling edge. A held item is replaced only after its transfer.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (rx_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    drive_item = rx_items.pop_front();
                    in_valid  <= 1'b1;
                    func      <= drive_item.is_tick;
                    rx_byte   <= drive_item.data;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples every channel on the rising edge, feeds the model
    // and checks each result against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        display_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            stall_cycles = stall_cycles + 1;
            if (cfg_valid && cfg_ready)
            begin
                stall_cycles = 0;
                case (cfg_index)
                    rtfr_pkg::CFG_TICKS_PER_SECOND: model_tps     = cfg_data[9:0];
                    rtfr_pkg::CFG_TIMEOUT_SECONDS:  model_timeout = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                in_taken     = 1'b1;
                stall_cycles = 0;
                receive_item('{is_tick: func, data: rx_byte});
            end
            if (out_valid && out_ready)
            begin
                stall_cycles = 0;
                if (pending_displays.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: display result with nothing pending: val=%0d ok=%b",
                                 $realtime, shown_value, reading_valid);
                end
                else
                begin
                    want = pending_displays.pop_front();
                    if (want.port_a !== port_a_leds || want.port_c !== port_c_leds ||
                        want.port_f !== port_f_leds || want.port_g !== port_g_leds ||
                        want.value  !== shown_value || want.valid  !== reading_valid)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("%0t: display mismatch exp a=%h c=%h f=%h g=%h val=%0d ok=%b got a=%h c=%h f=%h g=%h val=%0d ok=%b",
                                     $realtime, want.port_a, want.port_c, want.port_f,
                                     want.port_g, want.value, want.valid, port_a_leds,
                                     port_c_leds, port_f_leds, port_g_leds, shown_value,
                                     reading_valid);
                    end
                end
            end
        end
    end

    // Watchdog: no transfer on any channel for too long ends the run
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("tb_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic is_tick, input logic [7:0] data);
        rx_items.push_back('{is_tick: is_tick, data: data});
        items_queued = items_queued + 1;
    endtask

    // Key, then four salted copies. bad_copy flips one bit of that copy;
    // key_cut flips one bit of that key byte and drops the rest of the frame.
    task automatic push_frame(input logic [7:0] reading, input int bad_copy, input int key_cut);
        for (int k = 0; k < KEY_BYTES; k++)
        begin
            if (k == key_cut)
            begin
                push_item(1'b0, KEY_SEQ[k] ^ (8'h01 << $urandom_range(0, 7)));
                return;
            end
            push_item(1'b0, KEY_SEQ[k]);
        end
        for (int c = 0; c < COPIES; c++)
            push_item(1'b0, reading ^ SALT_SEQ[c] ^
                      ((c == bad_copy) ? (8'h01 << $urandom_range(0, 7)) : 8'h00));
    endtask

    // Readings spread over every display range
    function automatic logic [7:0] pick_reading();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(0, 9));
            1:       return 8'($urandom_range(10, 99));
            2:       return 8'($urandom_range(100, 199));
            3:       return 8'($urandom_range(200, 254));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic gen_random(input int count);
        int start;
        int r;
        int v;
        start = items_queued;
        while (items_queued - start < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                v = $urandom_range(0, 99);
                if (v < 72)
                    push_frame(pick_reading(), -1, -1);
                else if (v < 82)
                    push_frame(pick_reading(), $urandom_range(0, COPIES - 1), -1);
                else if (v < 92)
                    push_frame(pick_reading(), -1, $urandom_range(0, KEY_BYTES - 1));
                else
                    push_frame(8'hff, -1, -1);
            end
            else if (r < 82)
            begin
                repeat ($urandom_range(1, 6))
                    push_item(1'b1, 8'($urandom_range(0, 255)));
            end
            else
            begin
                // noise: random kind and byte
                repeat ($urandom_range(1, 4))
                    push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Wait until every item is sent and every display has come back, then
    // keep the clock running with no traffic so that a late display is still checked.
    task automatic drain();
        while (rx_items.size() != 0 || in_valid || pending_displays.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [rtfr_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int tps, input int timeout, input int send_pct,
                             input int recv_pct, input int count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_reg(rtfr_pkg::CFG_TICKS_PER_SECOND, 10'(tps));
        write_reg(rtfr_pkg::CFG_TIMEOUT_SECONDS, 10'(timeout));
        gen_random(count);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        send_idle_pct = 14;
        recv_idle_pct = 45;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset register values (250 ticks, 60 s)
        push_item(1'b1, 8'hff);            // ticks with extreme byte values
        push_item(1'b1, 8'h00);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'hff);            // repeated first key byte restarts at one
        push_frame(8'd254, -1, -1);        // hundreds digit forced to one
        push_frame(8'd0, 2, -1);           // copies disagree: dropped
        push_frame(8'hff, -1, -1);         // accepted but shown as dashes
        push_frame(8'd100, -1, 9);         // key broken midway
        push_frame(8'd7, -1, -1);          // single digit
        push_frame(8'd100, -1, -1);
        drain();

        // Every tick ends a second; zero timeout dashes the reading at once
        write_reg(rtfr_pkg::CFG_TICKS_PER_SECOND, 10'd0);
        write_reg(rtfr_pkg::CFG_TIMEOUT_SECONDS, 10'd0);
        push_item(1'b1, 8'h5a);
        push_item(1'b1, 8'ha5);
        push_frame(8'd63, -1, -1);
        push_item(1'b1, 8'h00);
        drain();

        // Tick count left above the limit after the limit is lowered
        write_reg(rtfr_pkg::CFG_TICKS_PER_SECOND, 10'd20);
        write_reg(rtfr_pkg::CFG_TIMEOUT_SECONDS, 10'd255);
        push_frame(8'd42, -1, -1);
        repeat (10) push_item(1'b1, 8'h33);
        drain();
        write_reg(rtfr_pkg::CFG_TICKS_PER_SECOND, 10'd3);
        push_item(1'b1, 8'hcc);
        drain();

        // Random traffic over register settings and idle mixes
        run_phase(1,    255, 14, 45, 200);
        run_phase(5,    2,   14, 45, 200);
        run_phase(1023, 0,   45, 14, 200);
        run_phase(3,    0,   45, 14, 200);
        run_phase(7,    60,  0,  0,  200);
        run_phase(2,    1,   0,  0,  200);

        if (pending_displays.size() != 0)
            $display("%0d predicted displays never arrived", pending_displays.size());
        if (mismatches == 0 && pending_displays.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
